@@ src/efwq_pkg.sv @@
// shared constants for the event flag wait queue unit
`timescale 1ns / 1ps

package efwq_pkg;

  // default sizes
  localparam int FLAG_COUNT_DEF   = 32;
  localparam int THREAD_COUNT_DEF = 32;

  // field widths
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 6;
  localparam int TID_W    = 6;
  localparam int STATUS_W = 2;
  localparam int MASK_W   = 32;

  // flags that have an allocation bit
  localparam int REG_FLAGS = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TAKE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GIVE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_VALUE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WATCH = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 2'd3;

endpackage

@@ src/efwq_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module efwq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/event_flag_wait_queue_unit.sv @@
// top level of the event flag wait queue unit
`timescale 1ns / 1ps

// kernel event flag unit: one signal bit and one waiter bitmap per flag
// request channel: in_valid / in_stall carrying cmd, flag_index, thread_id;
//   a beat is taken when in_valid is high and in_stall is low
// result channel: out_valid / out_stall carrying status, flag_value and
//   woken_mask; exactly one result beat per request beat
// config channel: cfg_valid / cfg_ready with cfg_data, written into the
//   allocation mask; cfg_ready is always high, write only while idle
// the synchronous read of the flag memory is issued at the request beat;
//   the update, the write back and the result register follow in S_UPDATE,
//   which waits while the result slot is still full
// a new request is taken only once the last one has left S_UPDATE, set by
//   the single read-modify-write of the flag memory per request
// reset clears the allocation mask, the result valid and the per-entry
//   valid bits, so every flag reads as clear with no waiters
// when the receiver stalls the result holds in the output register; one
//   further request may be accepted and is read, then waits for the slot
module event_flag_wait_queue_unit #(
  parameter int FLAG_COUNT   = efwq_pkg::FLAG_COUNT_DEF,
  parameter int THREAD_COUNT = efwq_pkg::THREAD_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [efwq_pkg::CMD_W-1:0]    cmd,
  input  logic [efwq_pkg::IDX_W-1:0]    flag_index,
  input  logic [efwq_pkg::TID_W-1:0]    thread_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [efwq_pkg::STATUS_W-1:0] status,
  output logic                          flag_value,
  output logic [efwq_pkg::MASK_W-1:0]   woken_mask,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [efwq_pkg::MASK_W-1:0]   cfg_data
);

  // only flags with an allocation bit need storage
  localparam int MEM_DEPTH = (FLAG_COUNT < efwq_pkg::REG_FLAGS) ? FLAG_COUNT
                                                                : efwq_pkg::REG_FLAGS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ENTRY_W   = THREAD_COUNT + 1;

  typedef enum logic [0:0] {
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state;

  // captured request
  logic [efwq_pkg::CMD_W-1:0]    cmd_q;
  logic [efwq_pkg::TID_W-1:0]    tid_q;
  logic [ADDR_W-1:0]             addr_q;
  logic [efwq_pkg::STATUS_W-1:0] chk_q;

  logic [efwq_pkg::MASK_W-1:0] allocated_mask;
  logic [MEM_DEPTH-1:0]        ent_valid;

  // memory ports
  logic               mem_we;
  logic               mem_re;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  // request checks at accept
  logic                          accept;
  logic [efwq_pkg::STATUS_W-1:0] chk_next;

  // update stage
  logic                          done;
  logic                          ent_ok;
  logic                          sig_cur;
  logic [THREAD_COUNT-1:0]       wait_cur;
  logic                          sig_next;
  logic [THREAD_COUNT-1:0]       wait_next;
  logic [THREAD_COUNT-1:0]       wait_low;
  logic [THREAD_COUNT-1:0]       tid_bit;
  logic                          tid_ok;
  logic [efwq_pkg::TID_W-1:0]    tid_m1;
  logic [efwq_pkg::STATUS_W-1:0] status_next;
  logic                          value_next;
  logic [THREAD_COUNT-1:0]       woken_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // index range and allocation check
  always_comb begin
    if (int'(flag_index) >= FLAG_COUNT) begin
      chk_next = efwq_pkg::ST_INVALID;
    end else if (flag_index >= efwq_pkg::IDX_W'(efwq_pkg::REG_FLAGS)) begin
      chk_next = efwq_pkg::ST_NOT_ALLOC;
    end else if (!allocated_mask[flag_index[4:0]]) begin
      chk_next = efwq_pkg::ST_NOT_ALLOC;
    end else begin
      chk_next = efwq_pkg::ST_OK;
    end
  end

  // read only entries that exist
  assign mem_re = accept && (chk_next == efwq_pkg::ST_OK);

  efwq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_q),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (flag_index[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  // result slot free now or emptied this cycle
  assign done   = (state == S_UPDATE) && (!out_valid || !out_stall);
  assign ent_ok = (chk_q == efwq_pkg::ST_OK);

  // an entry never written reads as clear with no waiters
  always_comb begin
    if (ent_ok && ent_valid[addr_q]) begin
      sig_cur  = mem_rdata[THREAD_COUNT];
      wait_cur = mem_rdata[THREAD_COUNT-1:0];
    end else begin
      sig_cur  = 1'b0;
      wait_cur = '0;
    end
  end

  assign tid_ok   = (tid_q != '0) && (tid_q <= efwq_pkg::TID_W'(THREAD_COUNT));
  assign tid_m1   = tid_q - efwq_pkg::TID_W'(1);
  assign tid_bit  = tid_ok ? (THREAD_COUNT'(1) << tid_m1) : '0;
  assign wait_low = wait_cur & (~wait_cur + THREAD_COUNT'(1));

  // command decode and entry update
  always_comb begin
    sig_next    = sig_cur;
    wait_next   = wait_cur;
    status_next = chk_q;
    value_next  = 1'b0;
    woken_next  = '0;
    if (ent_ok) begin
      case (cmd_q)
        efwq_pkg::CMD_TAKE: begin
          if (sig_cur) begin
            sig_next = 1'b0;
          end else begin
            wait_next   = wait_cur | tid_bit;
            status_next = efwq_pkg::ST_BLOCKED;
          end
        end
        efwq_pkg::CMD_GIVE: begin
          if (wait_cur == '0) begin
            sig_next = 1'b1;
          end else begin
            woken_next = wait_low;
            wait_next  = wait_cur & ~wait_low;
          end
        end
        efwq_pkg::CMD_SET: begin
          sig_next   = 1'b1;
          woken_next = wait_cur;
          wait_next  = '0;
        end
        efwq_pkg::CMD_CLEAR: begin
          sig_next = 1'b0;
        end
        efwq_pkg::CMD_VALUE: begin
          value_next = sig_cur;
        end
        efwq_pkg::CMD_WATCH: begin
          if (!sig_cur) begin
            wait_next   = wait_cur | tid_bit;
            status_next = efwq_pkg::ST_BLOCKED;
          end
        end
        default: begin
          // unknown commands leave the entry alone
        end
      endcase
    end
  end

  assign mem_we    = done && ent_ok;
  assign mem_wdata = {sig_next, wait_next};

  // control, request capture and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      allocated_mask <= '0;
      ent_valid      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        allocated_mask <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_UPDATE;
          end
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_UPDATE: begin
          if (done) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
          if (mem_we) begin
            ent_valid[addr_q] <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    // payload registers
    if (accept) begin
      cmd_q  <= cmd;
      tid_q  <= thread_id;
      addr_q <= flag_index[ADDR_W-1:0];
      chk_q  <= chk_next;
    end
    if (done) begin
      status     <= status_next;
      flag_value <= value_next;
      woken_mask <= efwq_pkg::MASK_W'(woken_next);
    end
  end

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the event flag wait queue unit
`timescale 1ns / 1ps

// keeps a copy of the flag state, works out each reply and checks returned beats
class flag_unit_scoreboard;
  typedef struct packed {
    logic [efwq_pkg::STATUS_W-1:0] status;
    logic                          value;
    logic [efwq_pkg::MASK_W-1:0]   woken;
  } flag_reply_t;

  logic [efwq_pkg::MASK_W-1:0]    alloc_mask;
  logic [efwq_pkg::REG_FLAGS-1:0] raised;
  logic [efwq_pkg::MASK_W-1:0]    waiters [efwq_pkg::REG_FLAGS];
  flag_reply_t                    awaited_replies [$];
  int fails, checked, blocked, wakes, rejected;

  function new();
    alloc_mask = '0;
    raised     = '0;
    foreach (waiters[f]) waiters[f] = '0;
    fails    = 0;
    checked  = 0;
    blocked  = 0;
    wakes    = 0;
    rejected = 0;
  endfunction

  // applies one request to the flag state and returns the reply it earns
  function flag_reply_t resolve_request(logic [efwq_pkg::CMD_W-1:0] op,
                                        logic [efwq_pkg::IDX_W-1:0] idx,
                                        logic [efwq_pkg::TID_W-1:0] tid);
    flag_reply_t r;
    logic [4:0]  f;
    logic [efwq_pkg::MASK_W-1:0] w;
    logic        can_queue;
    int          t;
    r = '0;
    f = idx[4:0];
    t = int'(tid);
    can_queue = (t >= 1) && (t <= efwq_pkg::THREAD_COUNT_DEF) && (t <= 32);
    if (int'(idx) >= efwq_pkg::FLAG_COUNT_DEF) begin
      r.status = efwq_pkg::ST_INVALID;
    end else if (int'(idx) >= efwq_pkg::REG_FLAGS || !alloc_mask[f]) begin
      r.status = efwq_pkg::ST_NOT_ALLOC;
    end else begin
      w = waiters[f];
      case (op)
        efwq_pkg::CMD_TAKE: begin
          if (raised[f]) begin
            raised[f] = 1'b0;
          end else begin
            if (can_queue) waiters[f][t-1] = 1'b1;
            r.status = efwq_pkg::ST_BLOCKED;
          end
        end
        efwq_pkg::CMD_GIVE: begin
          if (w == '0) begin
            raised[f] = 1'b1;
          end else begin
            r.woken    = w & (~w + 1'b1);
            waiters[f] = w & ~r.woken;
          end
        end
        efwq_pkg::CMD_SET: begin
          raised[f]  = 1'b1;
          r.woken    = w;
          waiters[f] = '0;
        end
        efwq_pkg::CMD_CLEAR: raised[f] = 1'b0;
        efwq_pkg::CMD_VALUE: r.value = raised[f];
        efwq_pkg::CMD_WATCH: begin
          if (!raised[f]) begin
            if (can_queue) waiters[f][t-1] = 1'b1;
            r.status = efwq_pkg::ST_BLOCKED;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function void note_request(logic [efwq_pkg::CMD_W-1:0] op,
                             logic [efwq_pkg::IDX_W-1:0] idx,
                             logic [efwq_pkg::TID_W-1:0] tid);
    awaited_replies.push_back(resolve_request(op, idx, tid));
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    fails++;
    if (fails <= 40)
      $display("mismatch on %s: got %0h, expected %0h (reply %0d)",
               what, got, want, checked);
  endtask

  task check_result(logic [efwq_pkg::STATUS_W-1:0] status, logic value,
                    logic [efwq_pkg::MASK_W-1:0] woken);
    flag_reply_t want;
    if (awaited_replies.size() == 0) begin
      report("unrequested beat", {30'd0, status}, '0);
      return;
    end
    want = awaited_replies.pop_front();
    checked++;
    if (want.status == efwq_pkg::ST_BLOCKED) blocked++;
    if (want.status == efwq_pkg::ST_INVALID || want.status == efwq_pkg::ST_NOT_ALLOC)
      rejected++;
    if (want.woken != '0) wakes++;
    if (status !== want.status) report("status", {30'd0, status}, {30'd0, want.status});
    if (value !== want.value) report("flag_value", {31'd0, value}, {31'd0, want.value});
    if (woken !== want.woken) report("woken_mask", woken, want.woken);
  endtask
endclass

module tb_top;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int PHASES       = 8;
  // command codes the unit does not decode
  localparam logic [efwq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [efwq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                          clk        = 1'b0;
  logic                          rst        = 1'b1;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic [efwq_pkg::CMD_W-1:0]    cmd        = '0;
  logic [efwq_pkg::IDX_W-1:0]    flag_index = '0;
  logic [efwq_pkg::TID_W-1:0]    thread_id  = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [efwq_pkg::STATUS_W-1:0] status;
  logic                          flag_value;
  logic [efwq_pkg::MASK_W-1:0]   woken_mask;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [efwq_pkg::MASK_W-1:0]   cfg_data   = '0;

  flag_unit_scoreboard flag_board = new();

  // true while both sides run back to back with no idling
  bit          quiet = 1'b0;
  int          requests_sent = 0;
  int          mask_writes = 0;
  int unsigned cycles = 0;

  event_flag_wait_queue_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .flag_index (flag_index),
    .thread_id  (thread_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .flag_value (flag_value),
    .woken_mask (woken_mask),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one request beat; valid stays up after acceptance so back to back beats
  // need no extra assignment in the accepting step
  task automatic send_request(input logic [efwq_pkg::CMD_W-1:0] c,
                              input logic [efwq_pkg::IDX_W-1:0] i,
                              input logic [efwq_pkg::TID_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    flag_index <= i;
    thread_id  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    flag_board.note_request(c, i, t);
    requests_sent++;
  endtask

  // drop valid and wait until every reply has come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (flag_board.awaited_replies.size() != 0) @(posedge clk);
  endtask

  // allocation mask write, only with the unit idle
  task automatic write_alloc(input logic [efwq_pkg::MASK_W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    flag_board.alloc_mask = m;
    mask_writes++;
  endtask

  // mostly sane kernel calls on a few hot, allocated flags; the rest is noise
  // over the whole field ranges
  task automatic make_request(output logic [efwq_pkg::CMD_W-1:0] c,
                              output logic [efwq_pkg::IDX_W-1:0] i,
                              output logic [efwq_pkg::TID_W-1:0] t);
    int cand;
    if ($urandom_range(0, 99) < 80) begin
      c    = efwq_pkg::CMD_W'($urandom_range(0, 5));
      cand = $urandom_range(0, 3);
      for (int k = 0; k < 8; k++) begin
        cand = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
        if (flag_board.alloc_mask[cand]) break;
      end
      i = efwq_pkg::IDX_W'(cand);
      // a small thread pool makes repeat waiters likely
      t = efwq_pkg::TID_W'(($urandom_range(0, 1) == 1) ? $urandom_range(1, 4)
                                                        : $urandom_range(1, 32));
    end else begin
      c = efwq_pkg::CMD_W'($urandom_range(0, 7));
      i = efwq_pkg::IDX_W'($urandom_range(0, 63));
      t = efwq_pkg::TID_W'($urandom_range(0, 63));
    end
  endtask

  // result side: check every accepted beat, then pick the next stall state
  int stall_left = 0;
  int open_left  = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      flag_board.check_result(status, flag_value, woken_mask);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (open_left > 0) begin
      open_left = open_left - 1;
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      open_left  = $urandom_range(1, 8);
      out_stall <= 1'b0;
    end
  end

  // watchdog on total run length
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d replies outstanding", cycles,
             flag_board.awaited_replies.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [efwq_pkg::CMD_W-1:0]  c;
    logic [efwq_pkg::IDX_W-1:0]  i;
    logic [efwq_pkg::TID_W-1:0]  t;
    logic [efwq_pkg::MASK_W-1:0] m;
    int                          items;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset mask: nothing allocated
    send_request(efwq_pkg::CMD_TAKE, 6'd0, 6'd1);
    send_request(efwq_pkg::CMD_VALUE, 6'd31, 6'd1);
    drain_replies();
    write_alloc('0);
    send_request(efwq_pkg::CMD_SET, 6'd5, 6'd2);
    drain_replies();

    // directed pass with every flag allocated
    write_alloc('1);
    send_request(efwq_pkg::CMD_TAKE,  6'd0,  6'd1);   // flag clear, thread 1 waits
    send_request(efwq_pkg::CMD_TAKE,  6'd0,  6'd1);   // same thread again, bitmap unchanged
    send_request(efwq_pkg::CMD_WATCH, 6'd0,  6'd32);  // highest thread waits
    send_request(efwq_pkg::CMD_TAKE,  6'd0,  6'd0);   // thread zero blocked, not queued
    send_request(efwq_pkg::CMD_WATCH, 6'd0,  6'd33);  // thread above range, not queued
    send_request(efwq_pkg::CMD_TAKE,  6'd0,  6'd63);
    send_request(efwq_pkg::CMD_GIVE,  6'd0,  6'd0);   // wakes lowest waiter, flag stays clear
    send_request(efwq_pkg::CMD_VALUE, 6'd0,  6'd0);
    send_request(efwq_pkg::CMD_SET,   6'd0,  6'd0);   // wakes the rest, flag stays set
    send_request(efwq_pkg::CMD_VALUE, 6'd0,  6'd0);
    send_request(efwq_pkg::CMD_WATCH, 6'd0,  6'd2);   // flag set, returns at once
    send_request(efwq_pkg::CMD_TAKE,  6'd0,  6'd5);   // consumes the flag
    send_request(efwq_pkg::CMD_GIVE,  6'd0,  6'd5);   // nobody waits, flag set
    send_request(efwq_pkg::CMD_CLEAR, 6'd0,  6'd5);
    send_request(efwq_pkg::CMD_VALUE, 6'd0,  6'd5);
    send_request(CMD_SPARE_LO, 6'd0, 6'd1);           // undecoded commands do nothing
    send_request(CMD_SPARE_HI, 6'd31, 6'd63);
    send_request(efwq_pkg::CMD_TAKE,  6'd32, 6'd3);   // first index past the flag count
    send_request(efwq_pkg::CMD_SET,   6'd63, 6'd3);
    send_request(efwq_pkg::CMD_TAKE,  6'd31, 6'd32);
    send_request(efwq_pkg::CMD_WATCH, 6'd31, 6'd1);
    send_request(efwq_pkg::CMD_GIVE,  6'd31, 6'd1);
    send_request(efwq_pkg::CMD_SET,   6'd31, 6'd1);
    send_request(efwq_pkg::CMD_VALUE, 6'd31, 6'd1);

    // random phases over a spread of allocation masks
    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      case (p)
        0: begin m = '1;                   items = 300; end
        1: begin m = 32'h5555_5555;        items = 200; end
        2: begin m = $urandom() | 32'h1;   items = 250; end
        3: begin m = 32'hAAAA_AAAA;        items = 200; end
        4: begin m = '0;                   items = 40;  end
        5: begin m = $urandom();           items = 250; end
        6: begin m = 32'h8000_000F;        items = 200; end
        default: begin m = '1;             items = 160; end
      endcase
      write_alloc(m);
      quiet = (p == 6);
      for (int n = 0; n < items; n++) begin
        make_request(c, i, t);
        send_request(c, i, t);
        // occasional stretches with no idling on either side
        if (n % 100 == 99) quiet = ($urandom_range(0, 4) == 0);
      end
    end
    quiet = 1'b0;

    drain_replies();
    repeat (8) @(posedge clk);

    $display("%0d requests under %0d mask writes; %0d replies checked", requests_sent,
             mask_writes, flag_board.checked);
    $display("%0d blocked, %0d with woken threads, %0d rejected, %0d mismatches",
             flag_board.blocked, flag_board.wakes, flag_board.rejected, flag_board.fails);
    if (flag_board.fails == 0 && flag_board.awaited_replies.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
